/* hdl/mcrc_pkg.sv */
package mcrc_pkg;

    // field widths fixed by the frame format
    localparam int IDENT_W    = 11;
    localparam int LENGTH_W   = 4;
    localparam int BYTE_W     = 8;
    localparam int INTERVAL_W = 16;
    localparam int LIMIT_W    = 10;
    localparam int PWM_W      = 10;
    localparam int REQ_W      = 2 * BYTE_W;

    // stream data widths
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // default widths of internal state
    localparam int DEF_SPEED_BITS = 10;
    localparam int DEF_TICK_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_ID    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SAFETY_ID     = 2'd3;

    // configuration reset values
    localparam logic [INTERVAL_W-1:0] RST_STEP_INTERVAL = 16'd10;
    localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT   = 10'd999;
    localparam logic [IDENT_W-1:0]    RST_COMMAND_ID    = 11'h080;
    localparam logic [IDENT_W-1:0]    RST_SAFETY_ID     = 11'h010;

    // command codes on the drive identifier
    localparam logic [BYTE_W-1:0] DRV_START     = 8'h01;
    localparam logic [BYTE_W-1:0] DRV_STOP      = 8'h02;
    localparam logic [BYTE_W-1:0] DRV_FORWARD   = 8'h03;
    localparam logic [BYTE_W-1:0] DRV_REVERSE   = 8'h04;
    localparam logic [BYTE_W-1:0] DRV_SET_SPEED = 8'h05;

    // codes on the safety identifier
    localparam logic [BYTE_W-1:0] SAFE_ESTOP = 8'h01;
    localparam logic [BYTE_W-1:0] SAFE_CLEAR = 8'h03;

    // minimum length of a set speed frame
    localparam logic [LENGTH_W-1:0] SET_SPEED_MIN_LEN = 4'd3;

    typedef enum logic [2:0] {
        ST_NONE        = 3'd0,
        ST_OK          = 3'd1,
        ST_LATCHED     = 3'd2,
        ST_MALFORMED   = 3'd3,
        ST_UNKNOWN     = 3'd4,
        ST_UNADDRESSED = 3'd5
    } status_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] step_interval;
        logic [LIMIT_W-1:0]    speed_limit;
        logic [IDENT_W-1:0]    command_id;
        logic [IDENT_W-1:0]    safety_id;
    } cfg_t;

    typedef struct packed {
        logic                  op;
        logic [IDENT_W-1:0]    frame_ident;
        logic [LENGTH_W-1:0]   frame_length;
        logic [BYTE_W-1:0]     command_byte;
        logic [BYTE_W-1:0]     speed_high;
        logic [BYTE_W-1:0]     speed_low;
    } item_t;

    typedef struct packed {
        logic [PWM_W-1:0] pwm_compare;
        logic             drive_enable;
        logic             reverse_dir;
        logic             estop_latched;
        logic             dir_change_waiting;
        status_t          status;
    } result_t;

endpackage

/* hdl/mcrc_cfg_regs.sv */
module mcrc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [mcrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mcrc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output mcrc_pkg::cfg_t                     cfg
);

    mcrc_pkg::cfg_t cfg_reg;

    // register file, written one register at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_interval <= mcrc_pkg::RST_STEP_INTERVAL;
            cfg_reg.speed_limit   <= mcrc_pkg::RST_SPEED_LIMIT;
            cfg_reg.command_id    <= mcrc_pkg::RST_COMMAND_ID;
            cfg_reg.safety_id     <= mcrc_pkg::RST_SAFETY_ID;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mcrc_pkg::REG_STEP_INTERVAL: begin
                    cfg_reg.step_interval <= cfg_wdata[mcrc_pkg::INTERVAL_W-1:0];
                end
                mcrc_pkg::REG_SPEED_LIMIT: begin
                    cfg_reg.speed_limit <= cfg_wdata[mcrc_pkg::LIMIT_W-1:0];
                end
                mcrc_pkg::REG_COMMAND_ID: begin
                    cfg_reg.command_id <= cfg_wdata[mcrc_pkg::IDENT_W-1:0];
                end
                mcrc_pkg::REG_SAFETY_ID: begin
                    cfg_reg.safety_id <= cfg_wdata[mcrc_pkg::IDENT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/mcrc_in_reg.sv */
module mcrc_in_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mcrc_pkg::S_TDATA_W-1:0]  s_data,
    input  logic                            s_op,
    output logic                            item_valid,
    output mcrc_pkg::item_t                 item,
    input  logic                            item_take
);

    logic            valid_reg;
    mcrc_pkg::item_t item_reg;

    // free when empty or when the held item moves on this cycle
    assign s_ready = !valid_reg || item_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // unpack the item, first field in the lowest bits
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg.op           <= s_op;
            item_reg.frame_ident  <= s_data[10:0];
            item_reg.frame_length <= s_data[14:11];
            item_reg.command_byte <= s_data[22:15];
            item_reg.speed_high   <= s_data[30:23];
            item_reg.speed_low    <= s_data[38:31];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* hdl/mcrc_ctrl.sv */
module mcrc_ctrl #(
    parameter int SPEED_BITS = mcrc_pkg::DEF_SPEED_BITS,
    parameter int TICK_BITS  = mcrc_pkg::DEF_TICK_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mcrc_pkg::cfg_t     cfg,
    input  mcrc_pkg::item_t    item,
    input  logic               update,
    output mcrc_pkg::result_t  result
);

    localparam int CMP_W = (TICK_BITS + 1 > mcrc_pkg::INTERVAL_W) ?
                           TICK_BITS + 1 : mcrc_pkg::INTERVAL_W;
    localparam logic [mcrc_pkg::REQ_W-1:0] SPEED_MAX =
        mcrc_pkg::REQ_W'((33'd1 << SPEED_BITS) - 33'd1);

    logic [SPEED_BITS-1:0] cur_speed_reg, cur_speed_next;
    logic [SPEED_BITS-1:0] tgt_speed_reg, tgt_speed_next;
    logic                  enabled_reg, enabled_next;
    logic                  dir_reg, dir_next;
    logic                  pending_reg, pending_next;
    logic                  req_dir_reg, req_dir_next;
    logic                  estop_reg, estop_next;
    logic [TICK_BITS-1:0]  ticks_reg, ticks_next;

    logic [TICK_BITS:0]          tick_sum;
    logic                        step_due;
    logic [mcrc_pkg::REQ_W-1:0]  req_speed;
    logic [mcrc_pkg::REQ_W-1:0]  limit_ext;
    logic [mcrc_pkg::REQ_W-1:0]  capped_limit;
    logic [mcrc_pkg::REQ_W-1:0]  capped_speed;
    logic [15:0]                 cur_wide;
    mcrc_pkg::status_t           status;

    // tick counter and step decision
    assign tick_sum = {1'b0, ticks_reg} + {{TICK_BITS{1'b0}}, 1'b1};
    assign step_due = CMP_W'(tick_sum) >= CMP_W'(cfg.step_interval);

    // requested speed, capped at the limit and at the speed width
    assign req_speed    = {item.speed_high, item.speed_low};
    assign limit_ext    = mcrc_pkg::REQ_W'(cfg.speed_limit);
    assign capped_limit = (req_speed > limit_ext) ? limit_ext : req_speed;
    assign capped_speed = (capped_limit > SPEED_MAX) ? SPEED_MAX : capped_limit;

    // next state for the item held in the input register
    always_comb begin
        cur_speed_next = cur_speed_reg;
        tgt_speed_next = tgt_speed_reg;
        enabled_next   = enabled_reg;
        dir_next       = dir_reg;
        pending_next   = pending_reg;
        req_dir_next   = req_dir_reg;
        estop_next     = estop_reg;
        ticks_next     = ticks_reg;
        status         = mcrc_pkg::ST_NONE;

        if (!item.op) begin
            // millisecond tick
            if (step_due) begin
                ticks_next = '0;
                if (cur_speed_reg == tgt_speed_reg) begin
                    if (pending_reg && (cur_speed_reg == '0)) begin
                        dir_next     = req_dir_reg;
                        pending_next = 1'b0;
                    end
                end else if (cur_speed_reg < tgt_speed_reg) begin
                    cur_speed_next = cur_speed_reg + 1'b1;
                end else begin
                    cur_speed_next = cur_speed_reg - 1'b1;
                end
            end else if (tick_sum[TICK_BITS]) begin
                ticks_next = '1;
            end else begin
                ticks_next = tick_sum[TICK_BITS-1:0];
            end
        end else if (item.frame_ident == cfg.safety_id) begin
            // safety frame
            if (item.frame_length == '0) begin
                status = mcrc_pkg::ST_UNADDRESSED;
            end else begin
                unique case (item.command_byte)
                    mcrc_pkg::SAFE_ESTOP: begin
                        estop_next     = 1'b1;
                        enabled_next   = 1'b0;
                        cur_speed_next = '0;
                        tgt_speed_next = '0;
                        pending_next   = 1'b0;
                        status         = mcrc_pkg::ST_OK;
                    end
                    mcrc_pkg::SAFE_CLEAR: begin
                        estop_next = 1'b0;
                        status     = mcrc_pkg::ST_OK;
                    end
                    default: begin
                        status = mcrc_pkg::ST_UNKNOWN;
                    end
                endcase
            end
        end else if (item.frame_ident == cfg.command_id) begin
            // drive command frame
            if (item.frame_length == '0) begin
                status = mcrc_pkg::ST_UNADDRESSED;
            end else if (estop_reg) begin
                status = mcrc_pkg::ST_LATCHED;
            end else begin
                unique case (item.command_byte)
                    mcrc_pkg::DRV_START: begin
                        enabled_next = 1'b1;
                        status       = mcrc_pkg::ST_OK;
                    end
                    mcrc_pkg::DRV_STOP: begin
                        enabled_next   = 1'b0;
                        cur_speed_next = '0;
                        tgt_speed_next = '0;
                        pending_next   = 1'b0;
                        status         = mcrc_pkg::ST_OK;
                    end
                    mcrc_pkg::DRV_FORWARD, mcrc_pkg::DRV_REVERSE: begin
                        // wanted direction is reverse only for the reverse code
                        if (cur_speed_reg == '0) begin
                            dir_next     = (item.command_byte == mcrc_pkg::DRV_REVERSE);
                            pending_next = 1'b0;
                        end else begin
                            req_dir_next   = (item.command_byte == mcrc_pkg::DRV_REVERSE);
                            pending_next   = 1'b1;
                            tgt_speed_next = '0;
                        end
                        status = mcrc_pkg::ST_OK;
                    end
                    mcrc_pkg::DRV_SET_SPEED: begin
                        if (item.frame_length < mcrc_pkg::SET_SPEED_MIN_LEN) begin
                            status = mcrc_pkg::ST_MALFORMED;
                        end else begin
                            tgt_speed_next = capped_speed[SPEED_BITS-1:0];
                            status         = mcrc_pkg::ST_OK;
                        end
                    end
                    default: begin
                        status = mcrc_pkg::ST_UNKNOWN;
                    end
                endcase
            end
        end else begin
            status = mcrc_pkg::ST_UNADDRESSED;
        end
    end

    // drive state, updated once per item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_speed_reg <= '0;
            tgt_speed_reg <= '0;
            enabled_reg   <= 1'b0;
            dir_reg       <= 1'b0;
            pending_reg   <= 1'b0;
            req_dir_reg   <= 1'b0;
            estop_reg     <= 1'b0;
            ticks_reg     <= '0;
        end else if (update) begin
            cur_speed_reg <= cur_speed_next;
            tgt_speed_reg <= tgt_speed_next;
            enabled_reg   <= enabled_next;
            dir_reg       <= dir_next;
            pending_reg   <= pending_next;
            req_dir_reg   <= req_dir_next;
            estop_reg     <= estop_next;
            ticks_reg     <= ticks_next;
        end
    end

    // result reflects the state after the item
    assign cur_wide = 16'(cur_speed_next);

    always_comb begin
        result.pwm_compare        = cur_wide[mcrc_pkg::PWM_W-1:0];
        result.drive_enable       = enabled_next;
        result.reverse_dir        = dir_next;
        result.estop_latched      = estop_next;
        result.dir_change_waiting = pending_next;
        result.status             = status;
    end

endmodule

/* hdl/mcrc_out_reg.sv */
module mcrc_out_reg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            load,
    input  mcrc_pkg::result_t               result,
    output logic                            free,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mcrc_pkg::M_TDATA_W-1:0]  m_data
);

    logic              valid_reg;
    mcrc_pkg::result_t result_reg;

    // can take a new result when empty or when the held one leaves now
    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

    // pack the result, first field in the lowest bits
    assign m_valid = valid_reg;
    assign m_data  = {7'd0,
                      result_reg.status,
                      result_reg.dir_change_waiting,
                      result_reg.estop_latched,
                      result_reg.reverse_dir,
                      result_reg.drive_enable,
                      result_reg.pwm_compare};

endmodule

/* hdl/motor_command_ramp_controller.sv */
// Motor command ramp controller.
// The slave stream carries one item per tick or received frame: tuser = 0
// for a one millisecond tick, 1 for a frame whose identifier, length and
// first three data bytes travel in tdata. Every item yields exactly one
// result item on the master stream with the drive state after the item
// (PWM compare, enable, direction, stop latch, pending direction change)
// and a status code.
// Registers are written through cfg_we / cfg_index / cfg_wdata: 0 step
// interval, 1 speed limit, 2 drive identifier, 3 safety identifier.
// An accepted item is loaded into the input register; the state update
// then runs it into the result register once that register has room.
// Throughput is one item per cycle while the receiver does not stall.
// Reset (aresetn low, synchronous) empties both registers, restores the
// register defaults and clears speed, target, enable, direction, stop latch
// and tick count.
// When the receiver stalls the result is held; one more item is taken into
// the input register and then s_axis_tready drops until the result leaves.
module motor_command_ramp_controller #(
    parameter int SPEED_BITS = mcrc_pkg::DEF_SPEED_BITS,
    parameter int TICK_BITS  = mcrc_pkg::DEF_TICK_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // frame_ident, frame_length, command_byte, speed_high, speed_low, zero fill
    input  logic [mcrc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // op
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pwm_compare, drive_enable, reverse_dir, estop_latched,
    // dir_change_waiting, status, zero fill
    output logic [mcrc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               cfg_we,
    input  logic [mcrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mcrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    mcrc_pkg::cfg_t    cfg;
    mcrc_pkg::item_t   item;
    mcrc_pkg::result_t result;
    logic              item_valid;
    logic              out_free;
    logic              advance;

    // an item moves when the result register has room
    assign advance = item_valid && out_free;

    mcrc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    mcrc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .s_data     (s_axis_tdata),
        .s_op       (s_axis_tuser),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (advance)
    );

    mcrc_ctrl #(
        .SPEED_BITS (SPEED_BITS),
        .TICK_BITS  (TICK_BITS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item),
        .update  (advance),
        .result  (result)
    );

    mcrc_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .result  (result),
        .free    (out_free),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_data  (m_axis_tdata)
    );

endmodule
